### rtl/core/u8u16_pkg.sv
// Shared types and status codes for the UTF-8 to 16-bit code unit decoder.
// Used by u8u16_step and utf8_to_utf16_decoder; depends on nothing else.
`default_nettype none

package u8u16_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned UnitW   = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned RemW    = 3;
  localparam int unsigned AccW    = 27;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_OVERLONG = 3'd1,
    ST_STRAY    = 3'd2,
    ST_TOOBIG   = 3'd3,
    ST_TRUNC    = 3'd4
  } status_t;

  typedef struct packed {
    logic [RemW-1:0] bytes_remaining;
    logic [AccW-1:0] accumulator;
    logic            aborted;
  } dec_state_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    status_t          status;
    logic             end_mark;
  } dec_result_t;

endpackage

`default_nettype wire

### rtl/core/u8u16_step.sv
// Combinational decode of one byte against the current decoder state.
// Depends on u8u16_pkg for the state, result and status types.
`default_nettype none

module u8u16_step
  import u8u16_pkg::*;
(
  input  dec_state_t        cur,
  input  logic [ByteW-1:0]  data_byte,
  input  logic              final_req,
  output dec_state_t        nxt,
  output logic              res_valid,
  output dec_result_t       res
);

  logic [RemW-1:0] rem_m1;
  logic [AccW-1:0] cont_bits;
  logic [AccW-1:0] acc_new;
  logic            is_lead;
  logic            fail;
  status_t         fail_status;

  assign rem_m1 = cur.bytes_remaining - RemW'(1);

  always_comb begin
    cont_bits = '0;
    unique case (rem_m1)
      3'd0:    cont_bits = {20'b0, data_byte[6:0]};
      3'd1:    cont_bits = {14'b0, data_byte[6:0], 6'b0};
      3'd2:    cont_bits = {8'b0, data_byte[6:0], 12'b0};
      3'd3:    cont_bits = {2'b0, data_byte[6:0], 18'b0};
      default: cont_bits = '0;
    endcase
  end

  assign acc_new = cur.accumulator | cont_bits;

  always_comb begin
    nxt           = cur;
    res_valid     = 1'b0;
    res.code_unit = '0;
    res.status    = ST_OK;
    res.end_mark  = final_req;
    is_lead       = 1'b0;
    fail          = 1'b0;
    fail_status   = ST_OK;

    if (cur.aborted) begin
      if (final_req) begin
        nxt.aborted = 1'b0;
      end
    end else if (cur.bytes_remaining == '0) begin
      unique casez (data_byte)
        8'b0???????: begin
          res_valid     = 1'b1;
          res.code_unit = {9'b0, data_byte[6:0]};
        end
        8'b10??????: begin
          fail        = 1'b1;
          fail_status = ST_STRAY;
        end
        8'b110?????: begin
          is_lead             = 1'b1;
          nxt.bytes_remaining = 3'd1;
          nxt.accumulator     = {16'b0, data_byte[4:0], 6'b0};
        end
        8'b1110????: begin
          is_lead             = 1'b1;
          nxt.bytes_remaining = 3'd2;
          nxt.accumulator     = {11'b0, data_byte[3:0], 12'b0};
        end
        8'b11110???: begin
          is_lead             = 1'b1;
          nxt.bytes_remaining = 3'd3;
          nxt.accumulator     = {6'b0, data_byte[2:0], 18'b0};
        end
        8'b111110??: begin
          is_lead             = 1'b1;
          nxt.bytes_remaining = 3'd4;
          nxt.accumulator     = {1'b0, data_byte[1:0], 24'b0};
        end
        default: begin
          fail        = 1'b1;
          fail_status = ST_OVERLONG;
        end
      endcase
      if (is_lead && final_req) begin
        fail        = 1'b1;
        fail_status = ST_TRUNC;
      end
    end else begin
      nxt.bytes_remaining = rem_m1;
      nxt.accumulator     = acc_new;
      if (rem_m1 == '0) begin
        nxt.accumulator = '0;
        if (|acc_new[AccW-1:UnitW]) begin
          fail        = 1'b1;
          fail_status = ST_TOOBIG;
        end else begin
          res_valid     = 1'b1;
          res.code_unit = acc_new[UnitW-1:0];
        end
      end else if (final_req) begin
        fail        = 1'b1;
        fail_status = ST_TRUNC;
      end
    end

    if (fail) begin
      res_valid           = 1'b1;
      res.code_unit       = '0;
      res.status          = fail_status;
      nxt.bytes_remaining = '0;
      nxt.accumulator     = '0;
      nxt.aborted         = !final_req;
    end
  end

endmodule

`default_nettype wire

### rtl/core/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to 16-bit code unit decoder: state and result registers.
// Depends on u8u16_pkg and u8u16_step.
//
// Usage: the input channel carries one UTF-8 byte per transaction with
// in_final_req marking the last byte of a string. The result channel carries
// a 16-bit code unit, a status code and an end mark. A character yields one
// result when its last byte arrives; lead bytes and middle continuation bytes
// yield none unless they end the string, and after an error the bytes up to
// the next final byte yield none. A result appears on the output register in
// the cycle after the byte that completes it is accepted. Throughput is one
// byte per cycle while in_stall is low, set by the single decode step between
// the state register and the output register. When the receiver stalls, the
// output register holds its transaction and in_stall is raised whenever it
// holds a valid result; an empty or draining output register keeps the input
// open. Reset is synchronous and active low: it empties the output register,
// clears the decoder state to idle and stalls the input while asserted.
`default_nettype none

module utf8_to_utf16_decoder
  import u8u16_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ByteW-1:0]   in_data_byte,
  input  logic               in_final_req,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [UnitW-1:0]   out_code_unit,
  output logic [StatusW-1:0] out_status,
  output logic               out_end_mark
);

  dec_state_t  state_r;
  dec_state_t  state_nxt;
  dec_result_t res_r;
  dec_result_t res_nxt;
  logic        res_hit;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        in_accept;

  assign in_stall  = !rst_n || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  u8u16_step u_step (
    .cur       (state_r),
    .data_byte (in_data_byte),
    .final_req (in_final_req),
    .nxt       (state_nxt),
    .res_valid (res_hit),
    .res       (res_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = res_hit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && res_hit) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code_unit = res_r.code_unit;
  assign out_status    = res_r.status;
  assign out_end_mark  = res_r.end_mark;

`ifndef SYNTH
  a_err_zero_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.status != ST_OK) |-> res_r.code_unit == '0)
    else $error("error result carries a nonzero code unit");

  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_final_req |=>
      (state_r.bytes_remaining == '0) && (state_r.accumulator == '0) && !state_r.aborted)
    else $error("decoder not idle after the final byte of a string");

  a_abort_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.aborted |-> state_r.bytes_remaining == '0)
    else $error("discarding input while a character is pending");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bytes_remaining <= RemW'(4))
    else $error("continuation count out of range");

  a_no_result_when_aborted: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && state_r.aborted |=> !out_valid_r)
    else $error("result produced while discarding input");
`endif

endmodule

`default_nettype wire

### dv/utf8_to_utf16_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_utf16_decoder. A scoreboard class predicts each code unit,
// status and end mark from the accepted bytes and checks the results in order under random flow.
// Depends on u8u16_pkg and the decoder RTL.

import u8u16_pkg::*;

class code_unit_predictor;
  dec_result_t due_units[$];
  logic [RemW-1:0] cont_left;
  logic [AccW-1:0] partial;
  bit discarding;
  int errors;
  int checked;
  int status_seen[5];

  function new();
    cont_left = '0;
    partial = '0;
    discarding = 1'b0;
    errors = 0;
    checked = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  function void emit(logic [UnitW-1:0] unit, status_t st, logic fin);
    dec_result_t r;
    r.code_unit = unit;
    r.status = st;
    r.end_mark = fin;
    due_units.push_back(r);
  endfunction

  function void abort(status_t st, logic fin);
    emit('0, st, fin);
    cont_left = '0;
    partial = '0;
    discarding = !fin;
  endfunction

  function void note_byte(logic [ByteW-1:0] b, logic fin);
    int ones;
    logic [31:0] wide;
    logic [ByteW-1:0] mask;
    if (discarding) begin
      if (fin) discarding = 1'b0;
      return;
    end
    if (cont_left == 0) begin
      if (!b[7]) begin
        emit({9'b0, b[6:0]}, ST_OK, fin);
        return;
      end
      ones = 0;
      while (ones < 8 && b[7 - ones]) ones++;
      if (ones >= 6) begin
        abort(ST_OVERLONG, fin);
      end else if (ones == 1) begin
        abort(ST_STRAY, fin);
      end else begin
        mask = 8'((1 << (8 - ones)) - 1);
        wide = 32'(b & mask) << ((ones - 1) * 6);
        partial = wide[AccW-1:0];
        cont_left = RemW'(ones - 1);
        if (fin) abort(ST_TRUNC, fin);
      end
      return;
    end
    cont_left = cont_left - 1'b1;
    wide = 32'(b[6:0]) << (cont_left * 6);
    partial = partial | wide[AccW-1:0];
    if (cont_left == 0) begin
      if (partial[AccW-1:UnitW] != 0) abort(ST_TOOBIG, fin);
      else emit(partial[UnitW-1:0], ST_OK, fin);
      partial = '0;
    end else if (fin) begin
      abort(ST_TRUNC, fin);
    end
  endfunction

  function void check_unit(logic [UnitW-1:0] unit, logic [StatusW-1:0] st, logic fin);
    dec_result_t want;
    if (due_units.size() == 0) begin
      if (errors < 40)
        $display("%0t: unexpected transaction: unit=%h status=%0d end=%0d",
                 $time, unit, st, fin);
      errors++;
      return;
    end
    want = due_units.pop_front();
    checked++;
    if (int'(want.status) < 5) status_seen[want.status]++;
    if (unit !== want.code_unit || st !== want.status || fin !== want.end_mark) begin
      if (errors < 40)
        $display("%0t: mismatch: expected unit=%h status=%0d end=%0d, got unit=%h status=%0d end=%0d",
                 $time, want.code_unit, want.status, want.end_mark, unit, st, fin);
      errors++;
    end
  endfunction
endclass

module utf8_to_utf16_decoder_tb;
  localparam int CycleLimit = 200000;
  localparam int RandomBytes = 400;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ByteW-1:0] in_data_byte = '0;
  logic in_final_req = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [UnitW-1:0] out_code_unit;
  logic [StatusW-1:0] out_status;
  logic out_end_mark;

  code_unit_predictor board;
  logic [ByteW-1:0] str[$];
  int burst_left = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int cycles = 0;
  int stall_mode = 0;

  utf8_to_utf16_decoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_final_req(in_final_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_code_unit(out_code_unit),
    .out_status(out_status),
    .out_end_mark(out_end_mark)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_unit(out_code_unit, out_status, out_end_mark);
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 4) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_final_req <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_str();
    foreach (str[i]) send_byte(str[i], i == str.size() - 1);
    strings_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.due_units.size() != 0) @(posedge clk);
  endtask

  task automatic add_char();
    int kind;
    int len;
    bit fit;
    logic [ByteW-1:0] lead;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      str.push_back(8'($urandom_range(0, 127)));
      return;
    end
    if (kind < 32) begin
      str.push_back(8'($urandom_range(8'hFC, 8'hFF)));
      return;
    end
    if (kind < 38) begin
      str.push_back(8'($urandom_range(8'h80, 8'hBF)));
      return;
    end
    if (kind < 46) begin
      str.push_back(8'($urandom));
      return;
    end
    len = (kind < 66) ? 1 : (kind < 86) ? 2 : (kind < 95) ? 3 : 4;
    fit = (len == 3) && ($urandom_range(0, 1) == 1);
    lead = (8'hFF << (7 - len)) | 8'($urandom_range(0, (1 << (6 - len)) - 1));
    if (fit) lead = 8'hF0;
    str.push_back(lead);
    for (int k = 0; k < len; k++) begin
      if (fit && k == 0) str.push_back({4'b1000, 4'($urandom)});
      else if ($urandom_range(0, 6) == 0) str.push_back(8'($urandom));
      else str.push_back({2'b10, 6'($urandom)});
    end
  endtask

  task automatic send_random_str();
    int chars;
    str.delete();
    chars = $urandom_range(1, 6);
    repeat (chars) add_char();
    if (str.size() > 1 && $urandom_range(0, 9) == 0) void'(str.pop_back());
    send_str();
  endtask

  initial begin
    int directed_bytes;
    bit paused;
    board = new();
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    str = {8'h7F}; send_str();
    str = {8'h00, 8'hC3, 8'hA9}; send_str();
    // The continuation byte is not checked, so its bit 6 lands in the code unit.
    str = {8'hC2, 8'hFF}; send_str();
    str = {8'hEF, 8'hBF, 8'hBF}; send_str();
    str = {8'hF4, 8'h80, 8'h80, 8'h80}; send_str();
    str = {8'hF8, 8'h80, 8'h80, 8'h80, 8'h80}; send_str();
    str = {8'hFC, 8'h41}; send_str();
    str = {8'hFF}; send_str();
    str = {8'h80, 8'hC3}; send_str();
    str = {8'hE2, 8'h82}; send_str();
    str = {8'hC3}; send_str();
    drain();
    directed_bytes = bytes_sent;

    while (bytes_sent - directed_bytes < RandomBytes) begin
      send_random_str();
      if (!paused && bytes_sent - directed_bytes >= RandomBytes / 2) begin
        drain();
        paused = 1'b1;
      end
    end
    drain();
    repeat (4) @(posedge clk);

    $display("Sent %0d bytes in %0d strings and checked %0d result transactions.",
             bytes_sent, strings_sent, board.checked);
    $display("Statuses seen: ok %0d, overlong %0d, stray %0d, too big %0d, truncated %0d.",
             board.status_seen[0], board.status_seen[1], board.status_seen[2],
             board.status_seen[3], board.status_seen[4]);
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
